### rtl/dmss_pkg.sv
// Shared constants, codes and types of the dot matrix scan scroller.
package dmss_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int ADDR_W      = $clog2(MAX_COLUMNS);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int STEP_W      = $clog2(LEN_W + 1);

	localparam logic [15:0] PERIOD_RESET  = 16'd1000;
	localparam logic [LEN_W-1:0] COLUMNS_RESET = LEN_W'(8);
	localparam logic [7:0]  MASK_FIRST    = 8'h80;
	localparam logic [7:0]  MASK_LAST     = 8'h01;
	localparam logic [3:0]  REPLACE_STEP  = 4'd8;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [1:0] MODE_STATIC  = 2'd0;
	localparam logic [1:0] MODE_REPLACE = 2'd1;
	localparam logic [1:0] MODE_SCROLL  = 2'd2;

	localparam logic [1:0] REG_PERIOD  = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	typedef struct packed {
		logic             go;
		logic [LEN_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} dmss_mod_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] rem;
	} dmss_mod_rsp_t;

endpackage

### rtl/dmss_mod_unit.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
module dmss_mod_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dmss_pkg::dmss_mod_req_t req,
	output dmss_pkg::dmss_mod_rsp_t rsp
);

	logic [dmss_pkg::LEN_W-1:0]  div_q;
	logic [dmss_pkg::LEN_W-1:0]  divisor_q;
	logic [dmss_pkg::ADDR_W-1:0] rem_q;
	logic [dmss_pkg::STEP_W-1:0] cnt_q;
	logic                        done_q;
	logic [dmss_pkg::LEN_W-1:0]  trial;
	logic [dmss_pkg::LEN_W-1:0]  trial_red;

	// remainder stays below divisor <= MAX_COLUMNS, so it fits ADDR_W bits
	assign trial     = {rem_q, div_q[dmss_pkg::LEN_W-1]};
	assign trial_red = (trial >= divisor_q) ? (trial - divisor_q) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q <= dmss_pkg::STEP_W'(dmss_pkg::LEN_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == dmss_pkg::STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			div_q     <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (cnt_q != '0) begin
			div_q <= {div_q[dmss_pkg::LEN_W-2:0], 1'b0};
			rem_q <= trial_red[dmss_pkg::ADDR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### rtl/dot_matrix_scan_scroller.sv
// Top level: column-scan controller for an 8x8 LED dot matrix with frame store.
// Write and restart items leave busy low. A tick holds busy through the remainder
// steps, the store read and the output register; done rises in the same cycle that
// busy falls. A tick that advances the start column adds a second pass through the
// same remainder unit, and then done pulses while busy is still high.
// arst_n clears scan state, sets registers to reset values; frame store is not cleared.
module dot_matrix_scan_scroller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  column_index,
	input  logic [7:0]  column_bits,
	output logic        done,
	output logic [7:0]  row_byte,
	output logic [7:0]  column_byte,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_ADV
	} state_t;

	state_t                       state_q;
	logic [15:0]                  period_q;
	logic [dmss_pkg::LEN_W-1:0]   columns_q;
	logic [1:0]                   mode_q;
	logic [dmss_pkg::ADDR_W-1:0]  start_col_q;
	logic [2:0]                   scan_q;
	logic [7:0]                   mask_q;
	logic [15:0]                  tick_q;
	logic                         adv_q;
	logic [3:0]                   step_q;
	logic                         done_q;
	logic [7:0]                   row_byte_q;
	logic [7:0]                   column_byte_q;
	logic [7:0]                   rd_q;
	logic [7:0]                   frame_q [dmss_pkg::MAX_COLUMNS];

	logic                         accept;
	logic                         tick_go;
	logic                         adv_go;
	logic [dmss_pkg::LEN_W-1:0]   len;
	logic [15:0]                  tick_next;
	logic                         mode_moves;
	dmss_pkg::dmss_mod_req_t      req;
	dmss_pkg::dmss_mod_rsp_t      rsp;

	assign accept  = start && (state_q == ST_IDLE);
	assign tick_go = accept && (kind == dmss_pkg::KIND_TICK);
	assign adv_go  = (state_q == ST_READ) && adv_q;

	always_comb begin
		if (columns_q == '0)
			len = dmss_pkg::LEN_W'(1);
		else if (columns_q > dmss_pkg::LEN_W'(dmss_pkg::MAX_COLUMNS))
			len = dmss_pkg::LEN_W'(dmss_pkg::MAX_COLUMNS);
		else
			len = columns_q;
	end

	assign tick_next  = tick_q + 16'd1;
	assign mode_moves = (mode_q == dmss_pkg::MODE_REPLACE) ||
		(mode_q == dmss_pkg::MODE_SCROLL);

	always_comb begin
		req.go      = tick_go || adv_go;
		req.divisor = len;
		if (adv_go)
			req.dividend = {1'b0, start_col_q} + dmss_pkg::LEN_W'(step_q);
		else
			req.dividend = {1'b0, start_col_q} + dmss_pkg::LEN_W'(scan_q);
	end

	dmss_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// frame store: unwritten entries must never be read; the user ensures this, the block does not enforce it
	always_ff @(posedge clk) begin
		if (accept && (kind == dmss_pkg::KIND_WRITE))
			frame_q[column_index] <= column_bits;
		if ((state_q == ST_ADDR) && rsp.done)
			rd_q <= frame_q[rsp.rem];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			period_q      <= dmss_pkg::PERIOD_RESET;
			columns_q     <= dmss_pkg::COLUMNS_RESET;
			mode_q        <= dmss_pkg::MODE_STATIC;
			start_col_q   <= '0;
			scan_q        <= '0;
			mask_q        <= dmss_pkg::MASK_FIRST;
			tick_q        <= '0;
			adv_q         <= 1'b0;
			step_q        <= '0;
			done_q        <= 1'b0;
			row_byte_q    <= '0;
			column_byte_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					dmss_pkg::REG_PERIOD:  period_q  <= cfg_data;
					dmss_pkg::REG_COLUMNS: columns_q <= cfg_data[dmss_pkg::LEN_W-1:0];
					dmss_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							dmss_pkg::KIND_TICK: begin
								column_byte_q <= ~mask_q;
								scan_q        <= scan_q + 3'd1;
								mask_q        <= (mask_q == dmss_pkg::MASK_LAST) ?
									dmss_pkg::MASK_FIRST : (mask_q >> 1);
								if (tick_next == period_q) begin
									tick_q <= '0;
									adv_q  <= mode_moves;
								end else begin
									tick_q <= tick_next;
									adv_q  <= 1'b0;
								end
								step_q  <= (mode_q == dmss_pkg::MODE_REPLACE) ?
									dmss_pkg::REPLACE_STEP : 4'd1;
								state_q <= ST_ADDR;
							end
							dmss_pkg::KIND_RESTART: begin
								start_col_q <= '0;
								scan_q      <= '0;
								mask_q      <= dmss_pkg::MASK_FIRST;
								tick_q      <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ADDR: begin
					if (rsp.done)
						state_q <= ST_READ;
				end
				ST_READ: begin
					row_byte_q <= ~rd_q;
					done_q     <= 1'b1;
					state_q    <= adv_q ? ST_ADV : ST_IDLE;
				end
				ST_ADV: begin
					if (rsp.done) begin
						start_col_q <= rsp.rem;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign row_byte    = row_byte_q;
	assign column_byte = column_byte_q;

endmodule

### rtl/dmss_checker.sv
// Port-level checks of the scan scroller and their bind to the top level.
module dmss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] kind,
	input logic       done,
	input logic [7:0] column_byte
);

	// a result follows only from tick work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_column_onecold: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot(~column_byte))
		else $error("column select not one-cold");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == dmss_pkg::KIND_TICK) |=> busy)
		else $error("tick transaction did not start work");

	a_other_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind != dmss_pkg::KIND_TICK) |=> (!busy && !done))
		else $error("non-tick transaction caused work or a result");

endmodule

bind dot_matrix_scan_scroller dmss_checker u_dmss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.kind        (kind),
	.done        (done),
	.column_byte (column_byte)
);
